### design/cpu_operand_address_unit_defines.svh
// Assertion macros for the operand address unit.
`ifndef CPU_OPERAND_ADDRESS_UNIT_DEFINES_SVH
`define CPU_OPERAND_ADDRESS_UNIT_DEFINES_SVH

// Clocked check, held off while reset is asserted.
`define COAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define COAU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/coau_pkg.sv
// Types, codes and helpers shared by the operand address unit.
package coau_pkg;

    localparam logic       FUNC_START = 1'b0;
    localparam logic       FUNC_RDATA = 1'b1;

    localparam logic       KIND_REQ  = 1'b0;
    localparam logic       KIND_DONE = 1'b1;

    localparam logic [3:0] MODE_IMPL = 4'd0;
    localparam logic [3:0] MODE_ACC  = 4'd1;
    localparam logic [3:0] MODE_IMM  = 4'd2;
    localparam logic [3:0] MODE_ZP   = 4'd3;
    localparam logic [3:0] MODE_ZPX  = 4'd4;
    localparam logic [3:0] MODE_ZPY  = 4'd5;
    localparam logic [3:0] MODE_REL  = 4'd6;
    localparam logic [3:0] MODE_ABS  = 4'd7;
    localparam logic [3:0] MODE_ABSX = 4'd8;
    localparam logic [3:0] MODE_ABSY = 4'd9;
    localparam logic [3:0] MODE_IND  = 4'd10;
    localparam logic [3:0] MODE_INDX = 4'd11;
    localparam logic [3:0] MODE_INDY = 4'd12;

    localparam logic [2:0] STEP_IDLE   = 3'd0;
    localparam logic [2:0] STEP_OP_LO  = 3'd1;
    localparam logic [2:0] STEP_OP_HI  = 3'd2;
    localparam logic [2:0] STEP_PTR_LO = 3'd3;
    localparam logic [2:0] STEP_PTR_HI = 3'd4;
    localparam logic [2:0] STEP_DATA   = 3'd5;

    typedef struct packed {
        logic        func;
        logic [3:0]  mode;
        logic [15:0] pc;
        logic [7:0]  x_reg;
        logic [7:0]  y_reg;
        logic [7:0]  acc_reg;
        logic        want_data;
        logic [7:0]  rdata;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] mem_addr;
        logic [15:0] eff_addr;
        logic [7:0]  data;
        logic [1:0]  pc_increment;
    } res_t;

    typedef struct packed {
        logic [3:0]  cur_mode;
        logic [15:0] saved_pc;
        logic [7:0]  saved_x;
        logic [7:0]  saved_y;
        logic        fetch_data;
        logic [2:0]  step;
        logic [7:0]  low_byte;
        logic [15:0] pointer;
    } state_t;

    function automatic logic [1:0] operand_len(input logic [3:0] m);
        logic [1:0] len;
        begin
            if (m <= MODE_ACC || m > MODE_INDY)
                len = 2'd0;
            else if (m >= MODE_ABS && m <= MODE_IND)
                len = 2'd2;
            else
                len = 2'd1;
            return len;
        end
    endfunction

endpackage

### design/coau_step.sv
// Next-state and result logic for one transaction of the operand address unit.
module coau_step (
    input  coau_pkg::state_t cur,
    input  coau_pkg::cmd_t   item,
    output coau_pkg::state_t nxt,
    output logic             has_result,
    output coau_pkg::res_t   result
);
    import coau_pkg::*;

    logic        req_en;
    logic [15:0] req_addr;
    logic        done_en;
    logic [15:0] done_eff;
    logic [7:0]  done_data;
    logic        resolve_en;
    logic [15:0] resolve_addr;
    logic [15:0] word;
    logic [7:0]  b;

    assign b    = item.rdata;
    assign word = {b, cur.low_byte};

    always_comb
    begin
        nxt          = cur;
        req_en       = 1'b0;
        req_addr     = '0;
        done_en      = 1'b0;
        done_eff     = '0;
        done_data    = '0;
        resolve_en   = 1'b0;
        resolve_addr = '0;

        if (item.func == FUNC_START)
        begin
            nxt.cur_mode   = item.mode;
            nxt.saved_pc   = item.pc;
            nxt.saved_x    = item.x_reg;
            nxt.saved_y    = item.y_reg;
            nxt.fetch_data = item.want_data;
            nxt.low_byte   = '0;
            nxt.pointer    = '0;
            nxt.step       = STEP_IDLE;
            unique case (item.mode)
                MODE_ACC:
                begin
                    done_en   = 1'b1;
                    done_data = item.acc_reg;
                end
                MODE_IMM:
                begin
                    if (item.want_data)
                    begin
                        nxt.pointer = item.pc;
                        nxt.step    = STEP_DATA;
                        req_en      = 1'b1;
                        req_addr    = item.pc;
                    end
                    else
                    begin
                        done_en = 1'b1;
                    end
                end
                MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_REL, MODE_ABS, MODE_ABSX,
                MODE_ABSY, MODE_IND, MODE_INDX, MODE_INDY:
                begin
                    nxt.step = STEP_OP_LO;
                    req_en   = 1'b1;
                    req_addr = item.pc;
                end
                default:
                begin
                    done_en = 1'b1;
                end
            endcase
        end
        else
        begin
            unique case (cur.step)
                STEP_OP_LO:
                begin
                    unique case (cur.cur_mode)
                        MODE_ZP:
                        begin
                            resolve_en   = 1'b1;
                            resolve_addr = {8'h00, b};
                        end
                        MODE_ZPX:
                        begin
                            resolve_en   = 1'b1;
                            resolve_addr = {8'h00, 8'(b + cur.saved_x)};
                        end
                        MODE_ZPY:
                        begin
                            resolve_en   = 1'b1;
                            resolve_addr = {8'h00, 8'(b + cur.saved_y)};
                        end
                        MODE_REL:
                        begin
                            done_en  = 1'b1;
                            done_eff = 16'({{8{b[7]}}, b} + cur.saved_pc);
                        end
                        MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND:
                        begin
                            nxt.low_byte = b;
                            nxt.step     = STEP_OP_HI;
                            req_en       = 1'b1;
                            req_addr     = 16'(cur.saved_pc + 16'd1);
                        end
                        MODE_INDX:
                        begin
                            nxt.pointer = {8'h00, 8'(b + cur.saved_x)};
                            nxt.step    = STEP_PTR_LO;
                            req_en      = 1'b1;
                            req_addr    = {8'h00, 8'(b + cur.saved_x)};
                        end
                        MODE_INDY:
                        begin
                            nxt.pointer = {8'h00, b};
                            nxt.step    = STEP_PTR_LO;
                            req_en      = 1'b1;
                            req_addr    = {8'h00, b};
                        end
                        default:
                        begin
                            nxt.step = STEP_IDLE;
                        end
                    endcase
                end
                STEP_OP_HI:
                begin
                    unique case (cur.cur_mode)
                        MODE_ABS:
                        begin
                            resolve_en   = 1'b1;
                            resolve_addr = word;
                        end
                        MODE_ABSX:
                        begin
                            resolve_en   = 1'b1;
                            resolve_addr = 16'(word + {8'h00, cur.saved_x});
                        end
                        MODE_ABSY:
                        begin
                            resolve_en   = 1'b1;
                            resolve_addr = 16'(word + {8'h00, cur.saved_y});
                        end
                        MODE_IND:
                        begin
                            nxt.pointer = word;
                            nxt.step    = STEP_PTR_LO;
                            req_en      = 1'b1;
                            req_addr    = word;
                        end
                        default:
                        begin
                            nxt.step = STEP_IDLE;
                        end
                    endcase
                end
                STEP_PTR_LO:
                begin
                    nxt.low_byte = b;
                    nxt.step     = STEP_PTR_HI;
                    req_en       = 1'b1;
                    if (cur.cur_mode == MODE_IND)
                    begin
                        // keep the page-wrap quirk: high byte comes from the same page
                        if (cur.pointer[7:0] == 8'hFF)
                            req_addr = {cur.pointer[15:8], 8'h00};
                        else
                            req_addr = 16'(cur.pointer + 16'd1);
                    end
                    else
                    begin
                        req_addr = {8'h00, 8'(cur.pointer[7:0] + 8'd1)};
                    end
                end
                STEP_PTR_HI:
                begin
                    resolve_en = 1'b1;
                    if (cur.cur_mode == MODE_INDY)
                        resolve_addr = 16'(word + {8'h00, cur.saved_y});
                    else
                        resolve_addr = word;
                end
                STEP_DATA:
                begin
                    done_en   = 1'b1;
                    done_eff  = (cur.cur_mode == MODE_IMM) ? 16'h0000 : cur.pointer;
                    done_data = b;
                end
                default:
                begin
                    nxt.step = STEP_IDLE;
                end
            endcase
        end

        // effective address known: fetch the data byte or finish
        if (resolve_en)
        begin
            if (cur.fetch_data)
            begin
                nxt.pointer = resolve_addr;
                nxt.step    = STEP_DATA;
                req_en      = 1'b1;
                req_addr    = resolve_addr;
            end
            else
            begin
                done_en  = 1'b1;
                done_eff = resolve_addr;
            end
        end

        if (done_en)
            nxt.step = STEP_IDLE;
    end

    always_comb
    begin
        result     = '0;
        has_result = req_en | done_en;
        if (done_en)
        begin
            result.kind         = KIND_DONE;
            result.eff_addr     = done_eff;
            result.data         = done_data;
            result.pc_increment = operand_len(nxt.cur_mode);
        end
        else if (req_en)
        begin
            result.kind     = KIND_REQ;
            result.mem_addr = req_addr;
        end
    end

endmodule

### design/cpu_operand_address_unit.sv
// Operand address unit: input register, sequencing logic, result register.
// An accepted transaction is held in the input register; its result, if any, goes to the result register.
// Throughput: one transaction per cycle unless the result register is full and stalled, which stalls the input.
// Transactions that cause no result (read data while idle) still pass through the input register.
// Reset (rst_n low, asynchronous) clears valids and the sequencer state to idle.
`include "cpu_operand_address_unit_defines.svh"

module cpu_operand_address_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  coau_pkg::cmd_t cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output coau_pkg::res_t res
);
    import coau_pkg::*;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    cmd_t   s1_item_reg;
    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    res_t   res_reg;
    logic   has_result;
    res_t   step_result;
    logic   s1_adv;
    logic   cmd_accept;

    coau_step u_step (
        .cur        (state_reg),
        .item       (s1_item_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .result     (step_result)
    );

    // advance unless the item has a result and the result register is full and stalled
    assign s1_adv     = s1_valid_reg && (!has_result || !res_valid_reg || !res_stall);
    assign cmd_stall  = s1_valid_reg && !s1_adv;
    assign cmd_accept = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (cmd_accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv && has_result)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_adv)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
            s1_item_reg <= cmd;
        if (s1_adv && has_result)
            res_reg <= step_result;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `COAU_ASSERT_ALWAYS(a_step_code_legal, !rst_n || (state_reg.step <= STEP_DATA), "sequencer step code out of range")
    `COAU_ASSERT(a_stall_needs_item, cmd_stall |-> s1_valid_reg, "stall raised with empty input register")
    `COAU_ASSERT(a_req_leaves_busy, s1_adv && has_result && step_result.kind == KIND_REQ |=> state_reg.step != STEP_IDLE, "read request issued but sequencer idle")
    `COAU_ASSERT(a_done_goes_idle, s1_adv && has_result && step_result.kind == KIND_DONE |=> state_reg.step == STEP_IDLE, "operand done but sequencer still busy")
    `COAU_ASSERT(a_done_no_mem_addr, res_valid && res.kind == KIND_DONE |-> res.mem_addr == 16'h0000, "done result carries a read address")

endmodule
